>>> hdl/battery_level_monitor_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the battery level monitor
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_MONITOR_UNIT_MACROS_SVH
`define BATTERY_LEVEL_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define BLM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/blm_pkg.sv
// ----------------------------------------------------------------------------
// Battery level monitor package
// Payload types, event and register codes and fixed constants.
// ----------------------------------------------------------------------------
package blm_pkg;

    // Field widths
    localparam int ADC_BITS   = 10;
    localparam int TIMER_BITS = 16;
    localparam int PCT_BITS   = 7;
    localparam int CFG_DATA_BITS = 16;

    // Event kinds
    typedef enum logic [2:0] {
        KIND_INIT   = 3'd0,
        KIND_TICK   = 3'd1,
        KIND_USB    = 3'd2,
        KIND_DCLICK = 3'd3,
        KIND_SLEEP  = 3'd4
    } kind_t;

    // Configuration register indices
    typedef enum logic [1:0] {
        CFG_FIRST_DELAY   = 2'd0,
        CFG_SAMPLE_PERIOD = 2'd1,
        CFG_LOW_PERCENT   = 2'd2,
        CFG_HIGH_PERCENT  = 2'd3
    } cfg_index_t;

    // Converter scaling: readings at or below RAW_LOW give 0 %, at or above
    // RAW_HIGH give 100 %; between them (raw - RAW_LOW) * 100 / 265.
    localparam logic [ADC_BITS-1:0] RAW_LOW  = ADC_BITS'(400);
    localparam logic [ADC_BITS-1:0] RAW_HIGH = ADC_BITS'(665);
    localparam int DIFF_BITS = 9;
    // 100 * ceil(2^24 / 265), exact for every offset below the span.
    localparam logic [22:0] SCALE_MUL = 23'd6331100;
    localparam int SCALE_SHIFT = 24;
    localparam logic [PCT_BITS-1:0] PCT_FULL = PCT_BITS'(100);

    // Register reset values
    localparam logic [TIMER_BITS-1:0] FIRST_DELAY_RST   = TIMER_BITS'(1000);
    localparam logic [TIMER_BITS-1:0] SAMPLE_PERIOD_RST = TIMER_BITS'(10000);
    localparam logic [PCT_BITS-1:0]   LOW_PERCENT_RST   = PCT_BITS'(10);
    localparam logic [PCT_BITS-1:0]   HIGH_PERCENT_RST  = PCT_BITS'(15);

    // One event item
    typedef struct packed {
        logic [2:0]            kind;
        logic [TIMER_BITS-1:0] elapsed_ms;
        logic [ADC_BITS-1:0]   adc_sample;
        logic                  charge_pin;
        logic                  usb_present;
    } event_t;

    // One result item
    typedef struct packed {
        logic [PCT_BITS-1:0] percent;
        logic                percent_valid;
        logic                sample_taken;
        logic                battery_good;
        logic                good_changed;
        logic                charging;
        logic                charging_changed;
        logic                show_request;
        logic                sleep_veto;
    } result_t;

endpackage

>>> hdl/battery_level_monitor_unit.sv
// ----------------------------------------------------------------------------
// Battery level monitor unit
// Event-driven battery sampler with percentage scaling, good/bad hysteresis,
// charge tracking, display requests and sleep veto.
// ----------------------------------------------------------------------------
// Usage:
// Events arrive on the in_valid/in_ready channel, one result per event leaves
// on the out_valid/out_ready channel. Configuration writes use the cfg_valid/
// cfg_ready channel with a register index and data; cfg_ready is always high
// and writes should only be issued while no event is in flight.
// Each event passes through an input register, a single stage of logic
// (countdown compare and a constant multiply for the percentage) and a
// result register. Throughput: one event per cycle while the receiver does
// not stall. When the receiver stalls, the result register holds and the
// input register still takes one further event if it is empty; input ready
// then drops until the result is transferred.
// Reset clears both pipeline registers, loads the configuration registers
// with their defaults, sets the countdown to the default first delay, clears
// the reading and the good flag, and marks USB attached and charging.
// ----------------------------------------------------------------------------
`include "battery_level_monitor_unit_macros.svh"

module battery_level_monitor_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  blm_pkg::event_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output blm_pkg::result_t out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [blm_pkg::CFG_DATA_BITS-1:0] cfg_data
);
    import blm_pkg::*;

    // Configuration registers
    logic [TIMER_BITS-1:0] first_delay_reg;
    logic [TIMER_BITS-1:0] sample_period_reg;
    logic [PCT_BITS-1:0]   low_pct_reg;
    logic [PCT_BITS-1:0]   high_pct_reg;

    // Monitor state
    logic [TIMER_BITS-1:0] countdown_reg, countdown_next;
    logic [PCT_BITS-1:0]   level_pct_reg, level_pct_next;
    logic                  level_valid_reg, level_valid_next;
    logic                  good_reg, good_next;
    logic                  usb_reg, usb_next;
    logic                  charging_reg, charging_next;

    // Pipeline registers
    logic    in_valid_reg;
    event_t  in_item_reg;
    logic    out_valid_reg;
    result_t out_item_reg, out_item_next;

    logic advance;
    logic process;

    // Percentage scaling
    logic [DIFF_BITS-1:0] raw_diff;
    logic [31:0]          scale_prod;
    logic [PCT_BITS-1:0]  sample_pct;

    // Handshake: the result register frees when empty or being transferred.
    assign advance   = !out_valid_reg || out_ready;
    assign process   = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign cfg_ready = 1'b1;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_delay_reg   <= FIRST_DELAY_RST;
            sample_period_reg <= SAMPLE_PERIOD_RST;
            low_pct_reg       <= LOW_PERCENT_RST;
            high_pct_reg      <= HIGH_PERCENT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_FIRST_DELAY:   first_delay_reg   <= cfg_data[TIMER_BITS-1:0];
                CFG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[TIMER_BITS-1:0];
                CFG_LOW_PERCENT:   low_pct_reg       <= cfg_data[PCT_BITS-1:0];
                CFG_HIGH_PERCENT:  high_pct_reg      <= cfg_data[PCT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Converter reading to clamped percentage; the divide by the span is a
    // multiply by its scaled reciprocal.
    assign raw_diff   = DIFF_BITS'(in_item_reg.adc_sample - RAW_LOW);
    assign scale_prod = 32'(raw_diff) * 32'(SCALE_MUL);

    always_comb
    begin
        if (in_item_reg.adc_sample <= RAW_LOW)
            sample_pct = '0;
        else if (in_item_reg.adc_sample >= RAW_HIGH)
            sample_pct = PCT_FULL;
        else
            sample_pct = scale_prod[SCALE_SHIFT +: PCT_BITS];
    end

    // Event processing: next state and result fields.
    always_comb
    begin
        countdown_next   = countdown_reg;
        level_pct_next   = level_pct_reg;
        level_valid_next = level_valid_reg;
        good_next        = good_reg;
        usb_next         = usb_reg;
        charging_next    = charging_reg;
        out_item_next    = '0;

        case (in_item_reg.kind)
            KIND_INIT:
            begin
                level_pct_next   = '0;
                level_valid_next = 1'b0;
                countdown_next   = first_delay_reg;
                usb_next         = 1'b1;
                charging_next    = 1'b1;
            end
            KIND_TICK:
            begin
                // A zero countdown means sampling is stopped until the next init.
                if (countdown_reg != '0)
                begin
                    if (countdown_reg > in_item_reg.elapsed_ms)
                    begin
                        countdown_next = countdown_reg - in_item_reg.elapsed_ms;
                    end
                    else
                    begin
                        level_pct_next             = sample_pct;
                        level_valid_next           = 1'b1;
                        out_item_next.sample_taken = 1'b1;
                        countdown_next             = sample_period_reg;
                        if (sample_pct < low_pct_reg && good_reg)
                        begin
                            good_next                  = 1'b0;
                            out_item_next.good_changed = 1'b1;
                        end
                        else if (!good_reg && sample_pct > high_pct_reg)
                        begin
                            good_next                  = 1'b1;
                            out_item_next.good_changed = 1'b1;
                        end
                    end
                end
                // Follow the charge pin while USB is attached.
                if (usb_reg && (in_item_reg.charge_pin != charging_reg))
                begin
                    charging_next                  = in_item_reg.charge_pin;
                    out_item_next.charging_changed = 1'b1;
                end
            end
            KIND_USB:
            begin
                usb_next = in_item_reg.usb_present;
                if (!in_item_reg.usb_present)
                begin
                    charging_next                  = 1'b0;
                    out_item_next.charging_changed = 1'b1;
                    out_item_next.show_request     = 1'b1;
                end
            end
            KIND_DCLICK:
            begin
                out_item_next.show_request = level_valid_reg;
            end
            KIND_SLEEP:
            begin
                out_item_next.sleep_veto = !level_valid_reg;
            end
            default:
            begin
            end
        endcase

        out_item_next.percent       = level_pct_next;
        out_item_next.percent_valid = level_valid_next;
        out_item_next.battery_good  = good_next;
        out_item_next.charging      = charging_next;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    // Result register and monitor state, updated together per event.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            countdown_reg   <= FIRST_DELAY_RST;
            level_pct_reg   <= '0;
            level_valid_reg <= 1'b0;
            good_reg        <= 1'b0;
            usb_reg         <= 1'b1;
            charging_reg    <= 1'b1;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                countdown_reg   <= countdown_next;
                level_pct_reg   <= level_pct_next;
                level_valid_reg <= level_valid_next;
                good_reg        <= good_next;
                usb_reg         <= usb_next;
                charging_reg    <= charging_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (process)
        begin
            out_item_reg <= out_item_next;
        end
    end

    // Checks on the result and the pipeline.
    `BLM_ASSERT_IMPL(a_taken_valid, clk, rst_n, out_valid && out_data.sample_taken, out_data.percent_valid, "sample taken without a valid reading")
    `BLM_ASSERT_IMPL(a_pct_range, clk, rst_n, out_valid, out_data.percent <= PCT_FULL, "percentage above full scale")
    `BLM_ASSERT_IMPL(a_veto_no_reading, clk, rst_n, out_valid && out_data.sleep_veto, !out_data.percent_valid, "sleep veto while a reading exists")
    `BLM_ASSERT_IMPL(a_result_state, clk, rst_n, out_valid, (out_data.battery_good == good_reg) && (out_data.charging == charging_reg), "result disagrees with monitor state")
    `BLM_ASSERT_IMPL(a_stall_full, clk, rst_n, in_valid_reg && out_valid && !out_ready, !in_ready, "input taken while both stages are full")

endmodule

>>> tb/battery_level_monitor_checker.sv
// ----------------------------------------------------------------------------
// Battery level monitor result checker
// Watches the event, result and register channels of the monitor, keeps its
// own model of the sampling timer, percentage scaling, good-flag hysteresis
// and charge tracking, and compares every result transfer field by field
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module battery_level_monitor_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  blm_pkg::event_t                   in_data,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  blm_pkg::result_t                  out_data,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [blm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output int                                fail_count,
    output int                                pending,
    output int                                results_checked,
    output int                                readings_taken,
    output int                                good_flips
);
    import blm_pkg::*;

    // Register copies as the monitor should hold them.
    logic [TIMER_BITS-1:0] delay_first;
    logic [TIMER_BITS-1:0] period_reload;
    logic [PCT_BITS-1:0]   thr_low;
    logic [PCT_BITS-1:0]   thr_high;

    // Monitor state as predicted.
    logic [TIMER_BITS-1:0] countdown;
    logic [PCT_BITS-1:0]   level;
    logic                  level_ok;
    logic                  good;
    logic                  usb_on;
    logic                  charge_on;

    // Predicted results, oldest first.
    result_t expected_results[$];

    // Print one line per mismatch and count them all.
    task automatic report(input string msg);
        fail_count++;
        $display("MISMATCH: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [6:0] got,
                               input logic [6:0] want);
        if (got !== want)
            report($sformatf("result %0d: %s is %0d, expected %0d",
                             results_checked, name, got, want));
    endtask

    // Apply one event to the predicted state and return the result it causes.
    function automatic result_t apply_event(input event_t ev);
        result_t r;
        int      offset;
        r = '0;
        case (ev.kind)
            KIND_INIT:
            begin
                level     = '0;
                level_ok  = 1'b0;
                countdown = delay_first;
                usb_on    = 1'b1;
                charge_on = 1'b1;
            end
            KIND_TICK:
            begin
                // A zero countdown means sampling has stopped until the next init.
                if (countdown != '0)
                begin
                    if (countdown > ev.elapsed_ms)
                        countdown = countdown - ev.elapsed_ms;
                    else
                    begin
                        // Clamp below and above the converter window, scale between.
                        if (ev.adc_sample <= RAW_LOW)
                            level = '0;
                        else if (ev.adc_sample >= RAW_HIGH)
                            level = PCT_FULL;
                        else
                        begin
                            offset = int'(ev.adc_sample) - int'(RAW_LOW);
                            level  = PCT_BITS'((offset * 100) /
                                               (int'(RAW_HIGH) - int'(RAW_LOW)));
                        end
                        level_ok       = 1'b1;
                        r.sample_taken = 1'b1;
                        countdown      = period_reload;
                        // Hysteresis on the good flag, using the new reading.
                        if (level < thr_low && good)
                        begin
                            good           = 1'b0;
                            r.good_changed = 1'b1;
                        end
                        else if (!good && level > thr_high)
                        begin
                            good           = 1'b1;
                            r.good_changed = 1'b1;
                        end
                    end
                end
                // The charge pin is followed only while USB is attached.
                if (usb_on && ev.charge_pin != charge_on)
                begin
                    charge_on          = ev.charge_pin;
                    r.charging_changed = 1'b1;
                end
            end
            KIND_USB:
            begin
                usb_on = ev.usb_present;
                if (!ev.usb_present)
                begin
                    charge_on          = 1'b0;
                    r.charging_changed = 1'b1;
                    r.show_request     = 1'b1;
                end
            end
            KIND_DCLICK:
                r.show_request = level_ok;
            KIND_SLEEP:
                r.sleep_veto = !level_ok;
            default:
            begin
            end
        endcase
        r.percent       = level;
        r.percent_valid = level_ok;
        r.battery_good  = good;
        r.charging      = charge_on;
        return r;
    endfunction

    // Follow the three channels; results are compared before new events are
    // predicted, since a result transfer always belongs to an earlier event.
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            delay_first   = FIRST_DELAY_RST;
            period_reload = SAMPLE_PERIOD_RST;
            thr_low       = LOW_PERCENT_RST;
            thr_high      = HIGH_PERCENT_RST;
            countdown     = FIRST_DELAY_RST;
            level         = '0;
            level_ok      = 1'b0;
            good          = 1'b0;
            usb_on        = 1'b1;
            charge_on     = 1'b1;
            expected_results.delete();
        end
        else
        begin
            // Register write transfer.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FIRST_DELAY:   delay_first   = cfg_data;
                    CFG_SAMPLE_PERIOD: period_reload = cfg_data;
                    CFG_LOW_PERCENT:   thr_low       = cfg_data[PCT_BITS-1:0];
                    CFG_HIGH_PERCENT:  thr_high      = cfg_data[PCT_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end

            // Result transfer.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report($sformatf("result transfer with no event outstanding, data %h",
                                     out_data));
                else
                begin
                    want = expected_results.pop_front();
                    check_field("percent", out_data.percent, want.percent);
                    check_field("percent_valid", out_data.percent_valid,
                                want.percent_valid);
                    check_field("sample_taken", out_data.sample_taken, want.sample_taken);
                    check_field("battery_good", out_data.battery_good, want.battery_good);
                    check_field("good_changed", out_data.good_changed, want.good_changed);
                    check_field("charging", out_data.charging, want.charging);
                    check_field("charging_changed", out_data.charging_changed,
                                want.charging_changed);
                    check_field("show_request", out_data.show_request, want.show_request);
                    check_field("sleep_veto", out_data.sleep_veto, want.sleep_veto);
                    results_checked++;
                    readings_taken += want.sample_taken;
                    good_flips     += want.good_changed;
                end
            end

            // Event transfer.
            if (in_valid && in_ready)
                expected_results.push_back(apply_event(in_data));
        end
        pending = expected_results.size();
    end

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// Battery level monitor testbench
// Drives directed and random events through the monitor under a series of
// register settings and handshake idling patterns, including a long result
// back-pressure stretch, while a separate checker predicts and compares
// every result.
// ----------------------------------------------------------------------------
module tb;
    import blm_pkg::*;

    localparam int           CYCLE_LIMIT       = 400000;
    localparam int           ITEMS_PER_PHASE   = 235;
    localparam int           PHASE_COUNT       = 8;
    localparam int           HOLD_CYCLES       = 40;
    localparam logic [2:0]   KIND_UNUSED_FIRST = 3'd5;
    localparam logic [2:0]   KIND_UNUSED_LAST  = 3'd7;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    event_t                   in_data   = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    result_t                  out_data;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [1:0]               cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

    int fail_count;
    int pending;
    int results_checked;
    int readings_taken;
    int good_flips;

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int hold_req        = 0;
    int hold_ack        = 0;
    int hold_left       = 0;
    int events_sent     = 0;
    int settings_used   = 1;
    int cycle_count     = 0;

    battery_level_monitor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    battery_level_monitor_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .in_data         (in_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_data        (out_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .readings_taken  (readings_taken),
        .good_flips      (good_flips)
    );

    // Clock, period 12.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off whenever one is
    // requested by the stimulus.
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offer one event and wait for its transfer. Called at a falling edge and
    // returns at a falling edge with valid still high, so that back-to-back
    // events need no gap.
    task automatic send_event(input logic [2:0] k, input logic [TIMER_BITS-1:0] el,
                              input logic [ADC_BITS-1:0] adc, input logic pin,
                              input logic usb);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{kind: k, elapsed_ms: el, adc_sample: adc,
                      charge_pin: pin, usb_present: usb};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        events_sent++;
        @(negedge clk);
    endtask

    // Stop offering and wait until every outstanding result has arrived.
    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Load a full register setting while the monitor is idle.
    task automatic apply_settings(input logic [15:0] fd, input logic [15:0] sp,
                                  input logic [15:0] lo, input logic [15:0] hi);
        drain();
        write_reg(CFG_FIRST_DELAY, fd);
        write_reg(CFG_SAMPLE_PERIOD, sp);
        write_reg(CFG_LOW_PERCENT, lo);
        write_reg(CFG_HIGH_PERCENT, hi);
        cfg_valid <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    // Stimulus.
    initial
    begin
        int               pick;
        logic [2:0]       k;
        logic [15:0]      el;
        logic [9:0]       adc;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset register values.
        send_event(KIND_SLEEP,  16'd0, 10'd0, 1'b0, 1'b0);       // veto, no reading
        send_event(KIND_DCLICK, 16'd0, 10'd0, 1'b0, 1'b0);       // no show yet
        send_event(KIND_USB,    16'd0, 10'd0, 1'b0, 1'b0);       // removal, show at 0 %
        send_event(KIND_USB,    16'd0, 10'd0, 1'b0, 1'b0);       // forced off again
        send_event(KIND_USB,    16'd0, 10'd0, 1'b0, 1'b1);       // attach
        send_event(KIND_TICK,   16'd0, 10'd0, 1'b1, 1'b0);       // charging back on
        send_event(KIND_TICK,   16'd999, 10'd1023, 1'b1, 1'b0);  // one ms left
        send_event(KIND_TICK,   16'd1, 10'd0, 1'b1, 1'b0);       // expiry, 0 %
        send_event(KIND_TICK,   16'hFFFF, 10'd1023, 1'b1, 1'b1); // full, turns good
        send_event(KIND_TICK,   16'hFFFF, 10'd400, 1'b1, 1'b0);  // low clamp, turns bad
        send_event(KIND_TICK,   16'hFFFF, 10'd401, 1'b1, 1'b0);
        send_event(KIND_TICK,   16'hFFFF, 10'd664, 1'b1, 1'b0);
        send_event(KIND_TICK,   16'hFFFF, 10'd665, 1'b1, 1'b0);
        send_event(KIND_TICK,   16'hFFFF, 10'd427, 1'b1, 1'b0);  // at low threshold
        send_event(KIND_TICK,   16'hFFFF, 10'd426, 1'b1, 1'b0);  // just below it
        send_event(KIND_TICK,   16'hFFFF, 10'd441, 1'b1, 1'b0);  // at high threshold
        send_event(KIND_TICK,   16'hFFFF, 10'd443, 1'b1, 1'b0);  // just above it
        send_event(KIND_DCLICK, 16'd0, 10'd0, 1'b0, 1'b0);
        send_event(KIND_SLEEP,  16'd0, 10'd0, 1'b0, 1'b0);
        for (int u = KIND_UNUSED_FIRST; u <= KIND_UNUSED_LAST; u++)
            send_event(3'(u), 16'hFFFF, 10'h3FF, 1'b1, 1'b1);
        send_event(KIND_TICK,   16'd5, 10'd0, 1'b0, 1'b0);       // charging off
        send_event(KIND_INIT,   16'd0, 10'd0, 1'b0, 1'b0);
        send_event(KIND_TICK,   16'hFFFF, 10'd532, 1'b0, 1'b0);  // reading and pin change

        // Random phases, each under its own setting and one of four idling patterns.
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            case (ph)
                0: apply_settings(16'd1000, 16'd10000, 16'd10, 16'd15);
                1: apply_settings(16'd1, 16'd1, 16'd0, 16'd100);
                2: apply_settings(16'hFFFF, 16'hFFFF, 16'd100, 16'd0);
                3: apply_settings(16'd0, 16'd50, 16'hFFFF, 16'hFFFF);   // sampling stopped
                4: apply_settings(16'd20, 16'd0, 16'd50, 16'd50);       // one reading per init
                6: apply_settings(16'd200, 16'd3000, 16'd40, 16'd60);
                default:
                    apply_settings(16'($urandom_range(1, 300)), 16'($urandom_range(1, 2000)),
                                   16'($urandom_range(0, 100)), 16'($urandom_range(0, 100)));
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                end
                1:
                begin
                    send_idle_pct  <= 57;
                    recv_stall_pct <= 0;
                end
                2:
                begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 57;
                end
                default:
                begin
                    send_idle_pct  <= 9;
                    recv_stall_pct <= 9;
                end
            endcase

            // Start every phase from init so the new first delay is used.
            send_event(KIND_INIT, 16'($urandom), 10'($urandom), 1'($urandom), 1'($urandom));
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Back-pressure stretch while events keep coming, then a full pause.
                if (ph % 4 == 0 && i == 60)
                    hold_req <= hold_req + 1;
                if (ph % 4 == 0 && i == 120)
                    drain();

                pick = $urandom_range(0, 99);
                if (pick < 4)
                    k = KIND_INIT;
                else if (pick < 62)
                    k = KIND_TICK;
                else if (pick < 74)
                    k = KIND_USB;
                else if (pick < 84)
                    k = KIND_DCLICK;
                else if (pick < 94)
                    k = KIND_SLEEP;
                else
                    k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));

                // Elapsed time mostly short, with the extremes mixed in.
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    el = 16'($urandom_range(0, 255));
                else if (pick < 70)
                    el = 16'($urandom_range(0, 4000));
                else if (pick < 85)
                    el = 16'($urandom);
                else if (pick < 95)
                    el = '0;
                else
                    el = 16'hFFFF;

                // Samples mostly around the converter window.
                if ($urandom_range(0, 99) < 60)
                    adc = 10'($urandom_range(390, 675));
                else
                    adc = 10'($urandom_range(0, 1023));

                send_event(k, el, adc, 1'($urandom), 1'($urandom));
            end
        end

        drain();
        repeat (5) @(negedge clk);

        $display("Covered %0d events under %0d register settings and four idling patterns.",
                 events_sent, settings_used);
        $display("Checked %0d results: %0d readings taken, %0d good-flag changes.",
                 results_checked, readings_taken, good_flips);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/blm_pkg.sv
hdl/battery_level_monitor_unit.sv
tb/battery_level_monitor_checker.sv
tb/tb.sv
